// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the refresh region controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/core/erc_pkg.sv
// Types, codes and helper functions of the refresh region controller.
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

  localparam int CoordW = 10;
  localparam int DimW   = 11;
  localparam int MaxDim = 1024;
  localparam int AreaW  = 22;

  localparam logic [DimW-1:0] PanelWidthRst  = 11'd960;
  localparam logic [DimW-1:0] PanelHeightRst = 11'd540;
  localparam logic [2:0]      PixelScaleRst  = 3'd1;
  localparam logic [7:0]      IntervalRst    = 8'd50;
  localparam logic [9:0]      DebounceRst    = 10'd120;

  localparam logic [2:0] RegPanelWidth  = 3'd0;
  localparam logic [2:0] RegPanelHeight = 3'd1;
  localparam logic [2:0] RegPixelScale  = 3'd2;
  localparam logic [2:0] RegInterval    = 3'd3;
  localparam logic [2:0] RegDebounce    = 3'd4;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_CLIP  = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_FLUSH = 3'd3,
    ACT_FULL  = 3'd4,
    ACT_TICK  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    STAT_NONE    = 3'd0,
    STAT_DEFER   = 3'd1,
    STAT_PARTIAL = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_CLIPPED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_CLIP,
    KIND_CLEAR,
    KIND_FLUSH,
    KIND_FULL,
    KIND_TICK,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
  } box_t;

  typedef struct packed {
    kind_e kind;
    logic  ok;
    box_t  box;
  } cls_item_t;

  typedef struct packed {
    logic [DimW-1:0]  eff_w;
    logic [DimW-1:0]  eff_h;
    logic [2:0]       scale;
    logic [7:0]       interval;
    logic [9:0]       debounce;
    logic [AreaW-1:0] area3;
  } cfg_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [2:0] eff_scale(input logic [2:0] v);
    logic [2:0] r;
    if (v == '0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/erc_channels.sv
// Valid/ready channel interfaces for event items and refresh results.
`timescale 1ns / 1ps
`default_nettype none

interface erc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [11:0] rect_left;
  logic signed [11:0] rect_top;
  logic [10:0]        rect_width;
  logic [10:0]        rect_height;

  modport source (output valid, action, rect_left, rect_top, rect_width, rect_height,
                  input ready);
  modport sink (input valid, action, rect_left, rect_top, rect_width, rect_height,
                output ready);
endinterface

interface erc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  logic [10:0] out_width;
  logic [10:0] out_height;

  modport source (output valid, status, out_x, out_y, out_width, out_height,
                  input ready);
  modport sink (input valid, status, out_x, out_y, out_width, out_height,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/epaper_refresh_region_controller.sv
// Top level of the e-paper refresh region controller.
//
//   channel   dir  handshake      carries
//   item_i    in   valid/ready    action, rect_left, rect_top, rect_width, rect_height
//   result_o  out  valid/ready    status, out_x, out_y, out_width, out_height
//   cfg_*     in   write enable   register index and write data
//
// One item per cycle sustained while the queue is not full; every item gives exactly one result.
// Each item passes through the classifier queue and then into the result register.
// The queue (QDEPTH entries) absorbs result stalls; item_i.ready drops only when it is full.
// Reset clears all box, counter and debounce state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module epaper_refresh_region_controller #(
  parameter int QDEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  erc_in_if.sink      item_i,
  erc_out_if.source   result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);
  import erc_pkg::*;

  localparam logic [AreaW-1:0] Area3Rst = AreaW'(960 * 540 * 3);

  logic [DimW-1:0]  pw_q, ph_q;
  logic [2:0]       scale_q;
  logic [7:0]       interval_q;
  logic [9:0]       debounce_q;
  logic [AreaW-1:0] area3_q, area3_d, area_m;
  cfg_t             cfg;

  logic       q_push, q_full, q_pop, q_valid;
  cls_item_t  q_wdata, q_rdata;

  always_comb begin
    cfg.eff_w    = eff_dim(pw_q);
    cfg.eff_h    = eff_dim(ph_q);
    cfg.scale    = eff_scale(scale_q);
    cfg.interval = interval_q;
    cfg.debounce = debounce_q;
    cfg.area3    = area3_q;
    area_m       = AreaW'(cfg.eff_w) * AreaW'(cfg.eff_h);
    area3_d      = area_m + {area_m[AreaW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q       <= PanelWidthRst;
      ph_q       <= PanelHeightRst;
      scale_q    <= PixelScaleRst;
      interval_q <= IntervalRst;
      debounce_q <= DebounceRst;
      area3_q    <= Area3Rst;
    end else begin
      area3_q <= area3_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPanelWidth:  pw_q       <= cfg_wdata_i;
          RegPanelHeight: ph_q       <= cfg_wdata_i;
          RegPixelScale:  scale_q    <= cfg_wdata_i[2:0];
          RegInterval:    interval_q <= cfg_wdata_i[7:0];
          RegDebounce:    debounce_q <= cfg_wdata_i[9:0];
          default: ;
        endcase
      end
    end
  end

  erc_front u_front (
    .cfg_i    (cfg),
    .item_i   (item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  erc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  erc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

  `ASSERT_CLK(a_partial_nonempty, clk_i, rst_ni, (result_o.valid && result_o.status == STAT_PARTIAL) |-> (result_o.out_width != '0 && result_o.out_height != '0), "partial refresh with empty region")
  `ASSERT_CLK(a_partial_in_range, clk_i, rst_ni, (result_o.valid && result_o.status == STAT_PARTIAL) |-> ((12'(result_o.out_x) + 12'(result_o.out_width)) <= 12'(MaxDim)), "partial refresh beyond coordinate range")
  `ASSERT_CLK(a_full_whole_panel, clk_i, rst_ni, (result_o.valid && result_o.status == STAT_FULL) |-> (result_o.out_x == '0 && result_o.out_y == '0 && result_o.out_width == cfg.eff_w && result_o.out_height == cfg.eff_h), "full refresh not covering panel")
  `ASSERT_NEVER(a_no_region_zero, clk_i, rst_ni, result_o.valid && (result_o.status == STAT_NONE || result_o.status == STAT_DEFER || result_o.status == STAT_CLIPPED) && (result_o.out_x != '0 || result_o.out_y != '0 || result_o.out_width != '0 || result_o.out_height != '0), "region fields set without refresh")

endmodule

`default_nettype wire

// File: rtl/core/erc_front.sv
// Front end: accepts event items, scales and clamps rectangles, classifies.
`timescale 1ns / 1ps
`default_nettype none

module erc_front (
  input  erc_pkg::cfg_t      cfg_i,
  erc_in_if.sink             item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output erc_pkg::cls_item_t q_data_o
);
  import erc_pkg::*;

  logic signed [15:0] sx, sy, ss, ws, hs;
  logic signed [15:0] b0, b1, b2, b3;
  logic signed [15:0] c0, c1, c2, c3;
  logic signed [15:0] wm1, hm1;
  logic               rect_ok;
  box_t               whole;

  assign item_i.ready = !q_full_i;
  assign q_push_o     = item_i.valid && !q_full_i;

  always_comb begin
    sx  = 16'(item_i.rect_left);
    sy  = 16'(item_i.rect_top);
    ss  = signed'({13'd0, cfg_i.scale});
    ws  = signed'(16'(item_i.rect_width) * 16'(cfg_i.scale));
    hs  = signed'(16'(item_i.rect_height) * 16'(cfg_i.scale));
    b0  = sx * ss;
    b1  = sy * ss;
    b2  = b0 + ws - 16'sd1;
    b3  = b1 + hs - 16'sd1;
    wm1 = signed'({5'd0, cfg_i.eff_w} - 16'd1);
    hm1 = signed'({5'd0, cfg_i.eff_h} - 16'd1);
    c0  = (b0 < 16'sd0) ? 16'sd0 : b0;
    c1  = (b1 < 16'sd0) ? 16'sd0 : b1;
    c2  = (b2 > wm1) ? wm1 : b2;
    c3  = (b3 > hm1) ? hm1 : b3;
    rect_ok = (item_i.rect_width != '0) && (item_i.rect_height != '0) &&
              (c2 >= c0) && (c3 >= c1);

    whole.x0 = '0;
    whole.y0 = '0;
    whole.x1 = CoordW'(cfg_i.eff_w - 11'd1);
    whole.y1 = CoordW'(cfg_i.eff_h - 11'd1);

    q_data_o.ok     = rect_ok;
    q_data_o.box.x0 = c0[CoordW-1:0];
    q_data_o.box.y0 = c1[CoordW-1:0];
    q_data_o.box.x1 = c2[CoordW-1:0];
    q_data_o.box.y1 = c3[CoordW-1:0];
    q_data_o.kind   = KIND_NOP;

    case (item_i.action)
      ACT_PUSH:  q_data_o.kind = KIND_PUSH;
      ACT_CLIP:  q_data_o.kind = KIND_CLIP;
      ACT_CLEAR: begin
        q_data_o.kind = KIND_CLEAR;
        q_data_o.ok   = 1'b1;
        q_data_o.box  = whole;
      end
      ACT_FLUSH: q_data_o.kind = KIND_FLUSH;
      ACT_FULL: begin
        q_data_o.kind = KIND_FULL;
        q_data_o.ok   = 1'b1;
        q_data_o.box  = whole;
      end
      ACT_TICK:  q_data_o.kind = KIND_TICK;
      default:   q_data_o.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/erc_queue.sv
// Short FIFO of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module erc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  erc_pkg::cls_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output erc_pkg::cls_item_t pop_data_o
);
  import erc_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cls_item_t         mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/erc_back.sv
// Back end: dirty and clip boxes, debounce, refresh decision, result register.
`timescale 1ns / 1ps
`default_nettype none

module erc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  erc_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  erc_pkg::cls_item_t q_data_i,
  output logic               q_pop_o,
  erc_out_if.source          result_o
);
  import erc_pkg::*;

  function automatic box_t merge(input logic valid, input box_t dst, input box_t b);
    box_t r;
    if (!valid) begin
      r = b;
    end else begin
      r.x0 = (b.x0 < dst.x0) ? b.x0 : dst.x0;
      r.y0 = (b.y0 < dst.y0) ? b.y0 : dst.y0;
      r.x1 = (b.x1 > dst.x1) ? b.x1 : dst.x1;
      r.y1 = (b.y1 > dst.y1) ? b.y1 : dst.y1;
    end
    return r;
  endfunction

  logic        dv_q, dv_d, cv_q, cv_d, ff_q, ff_d, pend_q, pend_d;
  box_t        dbox_q, dbox_d, cbox_q, cbox_d;
  logic [7:0]  parts_q, parts_d;
  logic [9:0]  ms_q, ms_d, rem_q, rem_d, rem_dec;
  logic        ov_q, ov_d;
  status_e     st_q, st_d;
  logic [9:0]  ox_q, ox_d, oy_q, oy_d;
  logic [10:0] ow_q, ow_d, oh_q, oh_d;

  logic        run_flush, bypass, f_dv, f_cv, f_ff;
  box_t        cut;
  logic        cut_empty, huge;
  logic [10:0] dw, dh;
  logic [21:0] prod;

  assign q_pop_o          = q_valid_i && (!ov_q || result_o.ready);
  assign result_o.valid      = ov_q;
  assign result_o.status     = st_q;
  assign result_o.out_x      = ox_q;
  assign result_o.out_y      = oy_q;
  assign result_o.out_width  = ow_q;
  assign result_o.out_height = oh_q;

  always_comb begin
    cut.x0 = (cv_q && cbox_q.x0 > dbox_q.x0) ? cbox_q.x0 : dbox_q.x0;
    cut.y0 = (cv_q && cbox_q.y0 > dbox_q.y0) ? cbox_q.y0 : dbox_q.y0;
    cut.x1 = (cv_q && cbox_q.x1 < dbox_q.x1) ? cbox_q.x1 : dbox_q.x1;
    cut.y1 = (cv_q && cbox_q.y1 < dbox_q.y1) ? cbox_q.y1 : dbox_q.y1;
    cut_empty = (cut.x1 < cut.x0) || (cut.y1 < cut.y0);
    dw   = {1'b0, cut.x1} - {1'b0, cut.x0} + 11'd1;
    dh   = {1'b0, cut.y1} - {1'b0, cut.y0} + 11'd1;
    prod = 22'(dw) * 22'(dh);
    huge = {prod[20:0], 2'b00} > {1'b0, cfg_i.area3};
  end

  always_comb begin
    dv_d    = dv_q;
    cv_d    = cv_q;
    ff_d    = ff_q;
    pend_d  = pend_q;
    dbox_d  = dbox_q;
    cbox_d  = cbox_q;
    parts_d = parts_q;
    ms_d    = ms_q;
    rem_d   = rem_q;
    rem_dec = (rem_q != '0) ? rem_q - 10'd1 : '0;
    run_flush = 1'b0;
    bypass    = 1'b0;
    f_dv      = dv_q;
    f_cv      = cv_q;
    f_ff      = ff_q;
    st_d = STAT_NONE;
    ox_d = '0;
    oy_d = '0;
    ow_d = '0;
    oh_d = '0;

    if (q_pop_o) begin
      case (q_data_i.kind)
        KIND_PUSH: begin
          if (q_data_i.ok) begin
            dbox_d = merge(dv_q, dbox_q, q_data_i.box);
            dv_d   = 1'b1;
          end
        end
        KIND_CLIP: begin
          if (q_data_i.ok) begin
            cbox_d = merge(cv_q, cbox_q, q_data_i.box);
            cv_d   = 1'b1;
          end else begin
            cv_d = 1'b0;
          end
        end
        KIND_CLEAR: begin
          dbox_d = merge(dv_q, dbox_q, q_data_i.box);
          dv_d   = 1'b1;
          ff_d   = 1'b1;
        end
        KIND_FLUSH: run_flush = 1'b1;
        KIND_FULL: begin
          run_flush = 1'b1;
          f_dv      = 1'b1;
          f_cv      = 1'b0;
          f_ff      = 1'b1;
        end
        KIND_TICK: begin
          if (ms_q != 10'h3FF) begin
            ms_d = ms_q + 10'd1;
          end
          if (pend_q) begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              pend_d    = 1'b0;
              run_flush = 1'b1;
              bypass    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (run_flush) begin
      if (!f_dv) begin
        cv_d = 1'b0;
      end else if (!bypass && !f_ff && (ms_q < cfg_i.debounce)) begin
        if (!pend_q) begin
          pend_d = 1'b1;
          rem_d  = cfg_i.debounce - ms_q;
        end
        st_d = STAT_DEFER;
      end else begin
        cv_d = 1'b0;
        if (f_cv && cut_empty) begin
          dv_d = 1'b0;
          st_d = STAT_CLIPPED;
        end else begin
          if (f_ff || huge || (parts_q >= cfg_i.interval)) begin
            st_d    = STAT_FULL;
            ow_d    = cfg_i.eff_w;
            oh_d    = cfg_i.eff_h;
            parts_d = '0;
            ff_d    = 1'b0;
          end else begin
            st_d = STAT_PARTIAL;
            ox_d = cut.x0;
            oy_d = cut.y0;
            ow_d = dw;
            oh_d = dh;
            if (parts_q != 8'hFF) begin
              parts_d = parts_q + 8'd1;
            end
          end
          dv_d = 1'b0;
          ms_d = '0;
        end
      end
    end

    if (q_pop_o) begin
      ov_d = 1'b1;
    end else if (result_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      st_q <= st_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      ow_q <= ow_d;
      oh_q <= oh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q    <= 1'b0;
      cv_q    <= 1'b0;
      ff_q    <= 1'b1;
      pend_q  <= 1'b0;
      dbox_q  <= '0;
      cbox_q  <= '0;
      parts_q <= '0;
      ms_q    <= '0;
      rem_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      dv_q    <= dv_d;
      cv_q    <= cv_d;
      ff_q    <= ff_d;
      pend_q  <= pend_d;
      dbox_q  <= dbox_d;
      cbox_q  <= cbox_d;
      parts_q <= parts_d;
      ms_q    <= ms_d;
      rem_q   <= rem_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_epaper_refresh_region_controller.sv
// Self-checking testbench: random and directed panel events against a refresh-region predictor.
`timescale 1ns / 1ps

module tb_epaper_refresh_region_controller;
  import erc_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int ResetCycles = 10;
  localparam int DrainCycles = 10;
  localparam int ReportLimit = 10;
  localparam int PhaseItems = 193;
  localparam int LongHold = 300;
  localparam int LongHoldEvery = 900;
  localparam int MsCeiling = 1023;
  localparam logic [2:0] ActSpareA = 3'd6;
  localparam logic [2:0] ActSpareB = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] left;
    logic [11:0] top;
    logic [10:0] width;
    logic [10:0] height;
  } evt_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [10:0] w;
    logic [10:0] h;
  } region_t;

  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } pbox_t;

  typedef enum {OP_ITEM, OP_CFG, OP_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    evt_t        evt;
    logic [2:0]  reg_idx;
    logic [10:0] reg_val;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [10:0] cfg_wdata_i = '0;
  logic        in_valid = 1'b0;
  evt_t        in_evt = '0;
  logic        out_ready = 1'b0;

  erc_in_if  item_if ();
  erc_out_if res_if ();

  assign item_if.valid       = in_valid;
  assign item_if.action      = in_evt.action;
  assign item_if.rect_left   = in_evt.left;
  assign item_if.rect_top    = in_evt.top;
  assign item_if.rect_width  = in_evt.width;
  assign item_if.rect_height = in_evt.height;
  assign res_if.ready        = out_ready;

  epaper_refresh_region_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // predictor settings and state
  logic [10:0] cfg_pw = PanelWidthRst;
  logic [10:0] cfg_ph = PanelHeightRst;
  logic [2:0]  cfg_scale = PixelScaleRst;
  logic [7:0]  cfg_every = IntervalRst;
  logic [9:0]  cfg_quiet_ms = DebounceRst;

  bit    dmg_valid = 1'b0;
  pbox_t dmg = '{0, 0, 0, 0};
  bit    win_valid = 1'b0;
  pbox_t win = '{0, 0, 0, 0};
  bit    full_owed = 1'b1;
  int    partial_run = 0;
  int    idle_ms = 0;
  bit    hold_pending = 1'b0;
  int    hold_left = 0;

  step_t   panel_events[$];
  region_t expected_regions[$];
  int      stim_items = 0;
  int      items_offered = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      mismatches = 0;

  function automatic int panel_dim(input logic [10:0] v);
    if (v == '0) return 1;
    if (int'(v) > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  function automatic int scale_of(input logic [2:0] v);
    if (v == '0) return 1;
    if (v > 3'd4) return 4;
    return int'(v);
  endfunction

  function automatic bit clip_to_panel(inout pbox_t b);
    int w;
    int h;
    w = panel_dim(cfg_pw);
    h = panel_dim(cfg_ph);
    if (b.x0 < 0) b.x0 = 0;
    if (b.y0 < 0) b.y0 = 0;
    if (b.x1 > w - 1) b.x1 = w - 1;
    if (b.y1 > h - 1) b.y1 = h - 1;
    return b.x1 >= b.x0 && b.y1 >= b.y0;
  endfunction

  function automatic void merge_into(inout bit ok, inout pbox_t dst, input pbox_t b);
    if (!ok) begin
      dst = b;
      ok = 1'b1;
      return;
    end
    if (b.x0 < dst.x0) dst.x0 = b.x0;
    if (b.y0 < dst.y0) dst.y0 = b.y0;
    if (b.x1 > dst.x1) dst.x1 = b.x1;
    if (b.y1 > dst.y1) dst.y1 = b.y1;
  endfunction

  function automatic void whole_panel_dirty();
    pbox_t b;
    b = '{0, 0, panel_dim(cfg_pw) - 1, panel_dim(cfg_ph) - 1};
    merge_into(dmg_valid, dmg, b);
  endfunction

  function automatic region_t run_refresh(input bit skip_wait);
    region_t r;
    pbox_t   b;
    int      dw;
    int      dh;
    int      pw;
    int      ph;
    bit      huge;
    r = '0;
    if (!dmg_valid) begin
      win_valid = 1'b0;
      return r;
    end
    if (!skip_wait && !full_owed && idle_ms < int'(cfg_quiet_ms)) begin
      if (!hold_pending) begin
        hold_pending = 1'b1;
        hold_left = int'(cfg_quiet_ms) - idle_ms;
      end
      r.status = STAT_DEFER;
      return r;
    end
    b = dmg;
    if (win_valid) begin
      if (b.x0 < win.x0) b.x0 = win.x0;
      if (b.y0 < win.y0) b.y0 = win.y0;
      if (b.x1 > win.x1) b.x1 = win.x1;
      if (b.y1 > win.y1) b.y1 = win.y1;
      win_valid = 1'b0;
      if (b.x1 < b.x0 || b.y1 < b.y0) begin
        dmg_valid = 1'b0;
        r.status = STAT_CLIPPED;
        return r;
      end
    end
    dw = b.x1 - b.x0 + 1;
    dh = b.y1 - b.y0 + 1;
    pw = panel_dim(cfg_pw);
    ph = panel_dim(cfg_ph);
    huge = longint'(dw) * longint'(dh) * 4 > longint'(pw) * longint'(ph) * 3;
    if (full_owed || huge || partial_run >= int'(cfg_every)) begin
      r.status = STAT_FULL;
      r.w = 11'(pw);
      r.h = 11'(ph);
      partial_run = 0;
      full_owed = 1'b0;
    end else begin
      r.status = STAT_PARTIAL;
      r.x = 10'(b.x0);
      r.y = 10'(b.y0);
      r.w = 11'(dw);
      r.h = 11'(dh);
      if (partial_run < 255) partial_run++;
    end
    dmg_valid = 1'b0;
    idle_ms = 0;
    return r;
  endfunction

  function automatic region_t predict_refresh(input evt_t e);
    region_t r;
    pbox_t   b;
    bit      kept;
    int      s;
    int      x;
    int      y;
    int      w;
    int      h;
    r = '0;
    s = scale_of(cfg_scale);
    x = int'($signed(e.left));
    y = int'($signed(e.top));
    w = int'(e.width);
    h = int'(e.height);
    case (e.action)
      ACT_PUSH: begin
        if (w != 0 && h != 0) begin
          b.x0 = x * s;
          b.y0 = y * s;
          b.x1 = b.x0 + w * s - 1;
          b.y1 = b.y0 + h * s - 1;
          kept = clip_to_panel(b);
          if (kept) merge_into(dmg_valid, dmg, b);
        end
      end
      ACT_CLIP: begin
        if (w == 0 || h == 0) begin
          win_valid = 1'b0;
        end else begin
          b.x0 = x * s;
          b.y0 = y * s;
          b.x1 = (x + w) * s - 1;
          b.y1 = (y + h) * s - 1;
          kept = clip_to_panel(b);
          if (kept) merge_into(win_valid, win, b);
          else win_valid = 1'b0;
        end
      end
      ACT_CLEAR: begin
        whole_panel_dirty();
        full_owed = 1'b1;
      end
      ACT_FLUSH: begin
        r = run_refresh(1'b0);
      end
      ACT_FULL: begin
        win_valid = 1'b0;
        whole_panel_dirty();
        full_owed = 1'b1;
        r = run_refresh(1'b0);
      end
      ACT_TICK: begin
        if (idle_ms < MsCeiling) idle_ms++;
        if (hold_pending) begin
          if (hold_left > 0) hold_left--;
          if (hold_left == 0) begin
            hold_pending = 1'b0;
            r = run_refresh(1'b1);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [10:0] val);
    case (idx)
      RegPanelWidth:  cfg_pw = val;
      RegPanelHeight: cfg_ph = val;
      RegPixelScale:  cfg_scale = val[2:0];
      RegInterval:    cfg_every = val[7:0];
      RegDebounce:    cfg_quiet_ms = val[9:0];
      default: begin
      end
    endcase
  endfunction

  // stimulus builders
  function automatic void add_event(input logic [2:0] act, input int left, input int top,
                                    input int w, input int h);
    step_t s;
    s.kind = OP_ITEM;
    s.evt.action = act;
    s.evt.left = 12'(left);
    s.evt.top = 12'(top);
    s.evt.width = 11'(w);
    s.evt.height = 11'(h);
    s.reg_idx = '0;
    s.reg_val = '0;
    panel_events.push_back(s);
    stim_items++;
  endfunction

  function automatic void add_setting(input logic [2:0] idx, input int val);
    step_t s;
    s.kind = OP_CFG;
    s.evt = '0;
    s.reg_idx = idx;
    s.reg_val = 11'(val);
    panel_events.push_back(s);
  endfunction

  function automatic void add_pause();
    step_t s;
    s.kind = OP_DRAIN;
    s.evt = '0;
    s.reg_idx = '0;
    s.reg_val = '0;
    panel_events.push_back(s);
  endfunction

  function automatic void add_noise_fields(input logic [2:0] act);
    add_event(act, $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 2047), $urandom_range(0, 2047));
  endfunction

  function automatic void add_rect(input logic [2:0] act, input int lw, input int lh);
    int k;
    int l;
    int t;
    int w;
    int h;
    k = $urandom_range(0, 19);
    l = int'($urandom_range(0, lw + 4)) - 4;
    t = int'($urandom_range(0, lh + 4)) - 4;
    if (k < 12) begin
      w = $urandom_range(1, lw / 4 + 1);
      h = $urandom_range(1, lh / 4 + 1);
    end else begin
      w = $urandom_range(1, lw + 2);
      h = $urandom_range(1, lh + 2);
    end
    if (k == 0) w = 0;
    if (k == 1) h = 0;
    if (k == 2) add_noise_fields(act);
    else add_event(act, l, t, w, h);
  endfunction

  function automatic void add_sequence(input int lw, input int lh, input int db);
    int run;
    repeat ($urandom_range(1, 4)) add_rect(ACT_PUSH, lw, lh);
    if ($urandom_range(0, 3) == 0) add_rect(ACT_CLIP, lw, lh);
    if ($urandom_range(0, 9) == 0) add_noise_fields(ACT_CLEAR);
    repeat ($urandom_range(0, 3)) add_noise_fields(ACT_TICK);
    if ($urandom_range(0, 9) == 0) add_noise_fields(ACT_FULL);
    else add_noise_fields(ACT_FLUSH);
    if ($urandom_range(0, 2) == 0) begin
      run = (db < 100) ? db + 2 : 100;
      repeat ($urandom_range(1, run)) add_noise_fields(ACT_TICK);
    end
  endfunction

  function automatic void add_phase(input int pw, input int ph, input int sc, input int iv,
                                    input int db);
    int stop;
    int lw;
    int lh;
    int k;
    add_setting(RegPanelWidth, pw);
    add_setting(RegPanelHeight, ph);
    add_setting(RegPixelScale, sc);
    add_setting(RegInterval, iv);
    add_setting(RegDebounce, db);
    lw = panel_dim(11'(pw)) / scale_of(3'(sc));
    lh = panel_dim(11'(ph)) / scale_of(3'(sc));
    if (lw < 1) lw = 1;
    if (lh < 1) lh = 1;
    stop = stim_items + PhaseItems;
    while (stim_items < stop) begin
      k = $urandom_range(0, 99);
      if (k < 70) add_sequence(lw, lh, db);
      else if (k < 97) add_noise_fields(3'($urandom_range(0, 7)));
      else add_pause();
    end
  endfunction

  function automatic int pick_gap(input bit calm);
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  step_t head;
  bit    go_valid;
  bit    go_we;
  int    send_gap = 0;
  bit    send_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && items_taken != items_offered)) begin
      go_valid = 1'b0;
      go_we = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (panel_events.size() != 0) begin
        head = panel_events[0];
        case (head.kind)
          OP_ITEM: begin
            go_valid = 1'b1;
            in_evt <= head.evt;
            void'(panel_events.pop_front());
            items_offered++;
            if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
          end
          OP_CFG: begin
            if (expected_regions.size() == 0) begin
              go_we = 1'b1;
              cfg_idx_i <= head.reg_idx;
              cfg_wdata_i <= head.reg_val;
              apply_setting(head.reg_idx, head.reg_val);
              void'(panel_events.pop_front());
            end
          end
          default: begin
            if (expected_regions.size() == 0) void'(panel_events.pop_front());
          end
        endcase
      end
      in_valid <= go_valid;
      cfg_we_i <= go_we;
    end
  end

  // result receiver
  bit go_ready;
  int recv_hold = 0;
  bit recv_calm = 1'b0;
  int next_long_at = 400;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      go_ready = 1'b1;
      if (recv_hold > 0) begin
        recv_hold--;
        go_ready = 1'b0;
      end else if (results_seen >= next_long_at) begin
        next_long_at += LongHoldEvery;
        recv_hold = LongHold;
        go_ready = 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
        if (!recv_calm && $urandom_range(0, 3) == 0) begin
          recv_hold = pick_gap(1'b0);
          go_ready = 1'b0;
        end
      end
      out_ready <= go_ready;
    end
  end

  // monitor and checker
  region_t want_r;
  region_t got_r;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        expected_regions.push_back(predict_refresh(in_evt));
        items_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        got_r.status = res_if.status;
        got_r.x = res_if.out_x;
        got_r.y = res_if.out_y;
        got_r.w = res_if.out_width;
        got_r.h = res_if.out_height;
        if (expected_regions.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected result %0d: status %0d x %0d y %0d w %0d h %0d",
                     results_seen, got_r.status, got_r.x, got_r.y, got_r.w, got_r.h);
          end
        end else begin
          want_r = expected_regions.pop_front();
          if (got_r !== want_r) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("result %0d: expected status %0d x %0d y %0d w %0d h %0d",
                       results_seen, want_r.status, want_r.x, want_r.y, want_r.w, want_r.h);
              $display("result %0d:   actual status %0d x %0d y %0d w %0d h %0d",
                       results_seen, got_r.status, got_r.x, got_r.y, got_r.w, got_r.h);
            end
          end
        end
        results_seen++;
      end
    end
  end

  initial begin
    add_noise_fields(ACT_FLUSH);
    add_event(ACT_PUSH, -2048, -2048, 2047, 2047);
    add_event(ACT_PUSH, 5, 5, 0, 9);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_setting(RegDebounce, 2);
    add_setting(RegInterval, 2);
    add_event(ACT_PUSH, 10, 20, 30, 40);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_event(ACT_TICK, 0, 0, 0, 0);
    add_event(ACT_TICK, 0, 0, 0, 0);
    add_event(ACT_PUSH, 2047, 2047, 5, 5);
    add_event(ACT_PUSH, 100, 100, 8, 8);
    add_event(ACT_CLIP, 0, 0, 0, 4);
    add_event(ACT_CLIP, 2000, 5, 4, 4);
    add_event(ACT_CLIP, 500, 400, 10, 10);
    add_event(ACT_TICK, 0, 0, 0, 0);
    add_event(ACT_TICK, 0, 0, 0, 0);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_event(ACT_PUSH, 1, 2, 3, 4);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_event(ACT_PUSH, 3, 3, 3, 3);
    add_event(ACT_TICK, 0, 0, 0, 0);
    add_event(ACT_TICK, 0, 0, 0, 0);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_event(ACT_CLEAR, 0, 0, 0, 0);
    add_event(ACT_FLUSH, 0, 0, 0, 0);
    add_event(ACT_FULL, 0, 0, 0, 0);
    add_event(ActSpareA, -1, -1, 2047, 2047);
    add_event(ActSpareB, 2047, 2047, 1, 1);

    add_phase(1024, 1024, 4, 255, 1023);
    add_phase(1, 1, 1, 1, 0);
    add_phase(0, 2047, 0, 0, 1);
    add_phase(320, 240, 2, 3, 5);
    add_phase(1024, 768, 7, 10, 20);
    add_phase(17, 900, 3, 255, 0);
    add_phase(600, 1000, 5, 2, 50);
    add_phase(2047, 0, 6, 20, 3);
    add_phase(800, 480, 2, 8, 10);
    add_phase(960, 540, 1, 50, 120);

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (panel_events.size() != 0 || items_taken != items_offered
           || expected_regions.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
